// ===== rtl/min_heap_timer_queue_assert.svh =====
// Assertion macros for the timer queue RTL.
`ifndef MIN_HEAP_TIMER_QUEUE_ASSERT_SVH
`define MIN_HEAP_TIMER_QUEUE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MHTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MHTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MHTQ_ASSERT(lbl, prop, msg)
`define MHTQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/mhtq_pkg.sv =====
// Types and constants shared by the timer queue modules.
`timescale 1ns / 1ps
package mhtq_pkg;

  localparam int ID_BITS  = 6;
  localparam int ID_COUNT = 64;
  localparam int MAX_POPS = 64;
  localparam int POPS_W   = 7;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_UPDATE = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] FUNC_TICK   = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [ID_BITS-1:0] timer_id;
    logic [31:0]        delay_seconds;
    logic [31:0]        now_seconds;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               expired_valid;
    logic [ID_BITS-1:0] expired_id;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic       load;
    logic       rd_dec;
    logic       take_add;
    logic       take_upd;
    logic       do_remove;
    logic       rd_last;
    logic       do_pop;
    logic       ld_held;
    logic       rd_parent;
    logic       par_move;
    logic       rd_left;
    logic       ld_left;
    logic       rd_right;
    logic       sel_right;
    logic       child_move;
    logic       wr_final;
    logic       rd_top;
    logic       set_status;
    logic [1:0] status;
    logic       emit;
    logic       emit_pend;
    logic       emit_last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       present;
    logic       full;
    logic       ptab_bad;
    logic       rem_is_last;
    logic       tick_ok;
    logic       cnt_one;
    logic       pos_zero;
    logic       parent_le;
    logic       has_left;
    logic       has_right;
    logic       right_lt;
    logic       child_lt;
    logic       out_free;
    logic       have_pend;
  } sts_t;

endpackage

// ===== rtl/mhtq_ctrl.sv =====
// Sequencer for the timer queue: decodes requests and steps heap sifts.
`timescale 1ns / 1ps
module mhtq_ctrl import mhtq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_LDH   = 4'd3;
  localparam logic [3:0] S_R_RD  = 4'd4;
  localparam logic [3:0] S_R_CMP = 4'd5;
  localparam logic [3:0] S_S_GO  = 4'd6;
  localparam logic [3:0] S_S_RDL = 4'd7;
  localparam logic [3:0] S_S_RDR = 4'd8;
  localparam logic [3:0] S_S_CMP = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;
  localparam logic [3:0] S_TCHK  = 4'd11;
  localparam logic [3:0] S_TDEC  = 4'd12;
  localparam logic [3:0] S_EMIT  = 4'd13;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.rd_dec = 1'b1;
        state_nxt = S_DISP;
      end
      S_DISP: begin
        if (sts.func == FUNC_TICK) begin
          state_nxt = S_TDEC;
        end else if (sts.func == FUNC_ADD && !sts.present) begin
          if (sts.full) begin
            cmd.set_status = 1'b1;
            cmd.status = ST_FULL;
            state_nxt = S_EMIT;
          end else begin
            cmd.take_add = 1'b1;
            state_nxt = S_R_RD;
          end
        end else if (!sts.present || sts.ptab_bad) begin
          cmd.set_status = 1'b1;
          cmd.status = ST_MISS;
          state_nxt = S_EMIT;
        end else if (sts.func == FUNC_REMOVE) begin
          cmd.do_remove = 1'b1;
          if (sts.rem_is_last) begin
            state_nxt = S_EMIT;
          end else begin
            cmd.rd_last = 1'b1;
            state_nxt = S_LDH;
          end
        end else begin
          cmd.take_upd = 1'b1;
          state_nxt = S_R_RD;
        end
      end
      S_LDH: begin
        cmd.ld_held = 1'b1;
        state_nxt = S_R_RD;
      end
      S_R_RD: begin
        if (sts.pos_zero) begin
          state_nxt = S_S_GO;
        end else begin
          cmd.rd_parent = 1'b1;
          state_nxt = S_R_CMP;
        end
      end
      S_R_CMP: begin
        if (sts.parent_le) begin
          state_nxt = S_S_GO;
        end else begin
          cmd.par_move = 1'b1;
          state_nxt = S_R_RD;
        end
      end
      S_S_GO: begin
        if (sts.has_left) begin
          cmd.rd_left = 1'b1;
          state_nxt = S_S_RDL;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_S_RDL: begin
        cmd.ld_left = 1'b1;
        if (sts.has_right) begin
          cmd.rd_right = 1'b1;
          state_nxt = S_S_RDR;
        end else begin
          state_nxt = S_S_CMP;
        end
      end
      S_S_RDR: begin
        cmd.sel_right = sts.right_lt;
        state_nxt = S_S_CMP;
      end
      S_S_CMP: begin
        if (sts.child_lt) begin
          cmd.child_move = 1'b1;
          state_nxt = S_S_GO;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.wr_final = 1'b1;
        state_nxt = (sts.func == FUNC_TICK) ? S_TCHK : S_EMIT;
      end
      S_TCHK: begin
        cmd.rd_top = 1'b1;
        state_nxt = S_TDEC;
      end
      S_TDEC: begin
        if (sts.have_pend) begin
          if (sts.out_free) begin
            cmd.emit = 1'b1;
            cmd.emit_pend = 1'b1;
            cmd.emit_last = !sts.tick_ok;
            if (sts.tick_ok) begin
              cmd.do_pop = 1'b1;
              cmd.rd_last = !sts.cnt_one;
              state_nxt = sts.cnt_one ? S_TCHK : S_LDH;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end else if (sts.tick_ok) begin
          cmd.do_pop = 1'b1;
          cmd.rd_last = !sts.cnt_one;
          state_nxt = sts.cnt_one ? S_TCHK : S_LDH;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/mhtq_datapath.sv =====
// Heap and position memories, presence flags, sift registers and result register.
`timescale 1ns / 1ps
`include "min_heap_timer_queue_assert.svh"
module mhtq_datapath import mhtq_pkg::*; #(
  parameter int CAPACITY  = 64,
  parameter int TIME_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  req_t in_data,
  input  logic out_ready,
  output logic out_valid,
  output rsp_t out_data,
  input  cmd_t cmd,
  output sts_t sts
);

  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = PW + 1;
  localparam int SW = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [TIME_BITS-1:0] hexp_mem [CAPACITY];
  logic [ID_BITS-1:0]   hid_mem  [CAPACITY];
  logic [PW-1:0]        ptab_mem [ID_COUNT];

  logic [1:0]           req_func_r;
  logic [ID_BITS-1:0]   req_id_r;
  logic [TIME_BITS-1:0] req_exp_r;
  logic [TIME_BITS-1:0] req_now_r;
  logic [CW-1:0]        cnt_r;
  logic [ID_COUNT-1:0]  pres_r;
  logic [TIME_BITS-1:0] hq_exp_r;
  logic [ID_BITS-1:0]   hq_id_r;
  logic [PW-1:0]        pq_r;
  logic [TIME_BITS-1:0] held_exp_r;
  logic [ID_BITS-1:0]   held_id_r;
  logic [PW-1:0]        pos_r;
  logic [TIME_BITS-1:0] child_exp_r;
  logic [ID_BITS-1:0]   child_id_r;
  logic [PW-1:0]        cidx_r;
  logic [ID_BITS-1:0]   pend_id_r;
  logic                 have_pend_r;
  logic [POPS_W-1:0]    pops_r;
  logic [1:0]           status_r;
  logic                 out_valid_r;
  rsp_t                 out_r;

  logic [SW-1:0]        sum_w;
  logic [TIME_BITS-1:0] now_w;
  logic [TIME_BITS-1:0] exp_w;
  logic [CW-1:0]        cnt_dec;
  logic [PW-1:0]        parent_idx;
  logic [CW-1:0]        left_full;
  logic [CW:0]          right_full;
  logic                 hrd_en;
  logic [PW-1:0]        hrd_addr;
  logic                 hwr_en;
  logic [PW-1:0]        hwr_addr;
  logic [TIME_BITS-1:0] hwr_exp;
  logic [ID_BITS-1:0]   hwr_id;
  logic                 out_free;

  assign now_w = TIME_BITS'(in_data.now_seconds);
  assign sum_w = SW'(now_w) + SW'(in_data.delay_seconds);
  assign exp_w = (|sum_w[SW-1:TIME_BITS]) ? {TIME_BITS{1'b1}} : sum_w[TIME_BITS-1:0];

  assign cnt_dec    = cnt_r - CW'(1);
  assign parent_idx = (pos_r - PW'(1)) >> 1;
  assign left_full  = {pos_r, 1'b1};
  assign right_full = {1'b0, left_full} + (CW+1)'(1);
  assign out_free   = !out_valid_r || out_ready;

  always_comb begin
    hrd_en = cmd.rd_dec | cmd.rd_top | cmd.rd_last | cmd.rd_parent | cmd.rd_left |
             cmd.rd_right;
    hrd_addr = '0;
    if (cmd.rd_last) hrd_addr = cnt_dec[PW-1:0];
    else if (cmd.rd_parent) hrd_addr = parent_idx;
    else if (cmd.rd_left) hrd_addr = left_full[PW-1:0];
    else if (cmd.rd_right) hrd_addr = right_full[PW-1:0];
  end

  always_comb begin
    hwr_en   = cmd.par_move | cmd.child_move | cmd.wr_final;
    hwr_addr = pos_r;
    hwr_exp  = held_exp_r;
    hwr_id   = held_id_r;
    if (cmd.par_move) begin
      hwr_exp = hq_exp_r;
      hwr_id  = hq_id_r;
    end else if (cmd.child_move) begin
      hwr_exp = child_exp_r;
      hwr_id  = child_id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (hwr_en) begin
      hexp_mem[hwr_addr] <= hwr_exp;
      hid_mem[hwr_addr]  <= hwr_id;
      ptab_mem[hwr_id]   <= hwr_addr;
    end
    if (hrd_en) begin
      hq_exp_r <= hexp_mem[hrd_addr];
      hq_id_r  <= hid_mem[hrd_addr];
    end
    if (cmd.rd_dec) pq_r <= ptab_mem[req_id_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pres_r      <= '0;
      out_valid_r <= 1'b0;
      have_pend_r <= 1'b0;
      pops_r      <= '0;
    end else begin
      if (cmd.take_add) begin
        cnt_r <= cnt_r + CW'(1);
        pres_r[req_id_r] <= 1'b1;
      end
      if (cmd.do_remove) begin
        cnt_r <= cnt_dec;
        pres_r[req_id_r] <= 1'b0;
      end
      if (cmd.do_pop) begin
        cnt_r <= cnt_dec;
        pres_r[hq_id_r] <= 1'b0;
        pops_r <= pops_r + POPS_W'(1);
        have_pend_r <= 1'b1;
      end
      if (cmd.load) begin
        pops_r <= '0;
        have_pend_r <= 1'b0;
      end
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func_r <= in_data.func;
      req_id_r   <= in_data.timer_id;
      req_exp_r  <= exp_w;
      req_now_r  <= now_w;
      status_r   <= ST_OK;
    end
    if (cmd.set_status) status_r <= cmd.status;
    if (cmd.take_add || cmd.take_upd) begin
      held_exp_r <= req_exp_r;
      held_id_r  <= req_id_r;
    end
    if (cmd.ld_held) begin
      held_exp_r <= hq_exp_r;
      held_id_r  <= hq_id_r;
    end
    if (cmd.take_add) pos_r <= cnt_r[PW-1:0];
    if (cmd.take_upd || cmd.do_remove) pos_r <= pq_r;
    if (cmd.do_pop) begin
      pos_r     <= '0;
      pend_id_r <= hq_id_r;
    end
    if (cmd.par_move) pos_r <= parent_idx;
    if (cmd.child_move) pos_r <= cidx_r;
    if (cmd.ld_left) begin
      child_exp_r <= hq_exp_r;
      child_id_r  <= hq_id_r;
      cidx_r      <= left_full[PW-1:0];
    end
    if (cmd.sel_right) begin
      child_exp_r <= hq_exp_r;
      child_id_r  <= hq_id_r;
      cidx_r      <= right_full[PW-1:0];
    end
    if (cmd.emit) begin
      if (cmd.emit_pend) begin
        out_r.status        <= ST_OK;
        out_r.expired_valid <= 1'b1;
        out_r.expired_id    <= pend_id_r;
        out_r.last          <= cmd.emit_last;
      end else begin
        out_r.status        <= status_r;
        out_r.expired_valid <= 1'b0;
        out_r.expired_id    <= '0;
        out_r.last          <= 1'b1;
      end
    end
  end

  always_comb begin
    sts.func        = req_func_r;
    sts.present     = pres_r[req_id_r];
    sts.full        = (cnt_r >= CAP_C);
    sts.ptab_bad    = ({1'b0, pq_r} >= cnt_r);
    sts.rem_is_last = ({1'b0, pq_r} == cnt_dec);
    sts.tick_ok     = (cnt_r != '0) && (hq_exp_r <= req_now_r) &&
                      (pops_r < POPS_W'(MAX_POPS));
    sts.cnt_one     = (cnt_r == CW'(1));
    sts.pos_zero    = (pos_r == '0);
    sts.parent_le   = (hq_exp_r <= held_exp_r);
    sts.has_left    = (left_full < cnt_r);
    sts.has_right   = (right_full < {1'b0, cnt_r});
    sts.right_lt    = (hq_exp_r < child_exp_r);
    sts.child_lt    = (child_exp_r < held_exp_r);
    sts.out_free    = out_free;
    sts.have_pend   = have_pend_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `MHTQ_ASSERT(a_cnt_cap, cnt_r <= CAP_C, "heap count above capacity")
  `MHTQ_ASSERT(a_emit_free, !cmd.emit || out_free, "result written over a waiting one")
  `MHTQ_ASSERT(a_pops_max, pops_r <= POPS_W'(MAX_POPS), "too many pops in one tick")
  `MHTQ_ASSERT_NEXT(a_add_grow, cmd.take_add, cnt_r == $past(cnt_r) + CW'(1),
                    "add did not grow the heap")

endmodule

// ===== rtl/min_heap_timer_queue.sv =====
// Timer queue top level: binary min-heap of expiries with id lookup.
// Input requests (in_valid/in_ready, in_data) carry func, timer_id, delay_seconds
// and now_seconds. Add, update and remove each give one result with a status;
// tick gives one result per expired timer, earliest first, at most 64, with
// last set on the final one, or a single empty result when nothing expired.
// One request is handled at a time; in_ready is high only while idle.
// Each request is first decoded, then sifted through the heap memory, which has
// one read port: a level moved up reads the parent and compares, a level moved
// down reads the left child, then the right child if there is one, and compares.
// On tick, a sift down from the root follows each pop that leaves timers behind.
// Results go to an output register (out_valid/out_ready); while the receiver
// stalls, the sequencer waits before writing the next result, and the heap
// state holds. Reset (rst_n low, synchronous) empties the heap and clears the
// presence flags; no clearing pass is needed, requests are taken right away.
`timescale 1ns / 1ps
module min_heap_timer_queue import mhtq_pkg::*; #(
  parameter int CAPACITY  = 64,
  parameter int TIME_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  cmd_t cmd;
  sts_t sts;

  mhtq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  mhtq_datapath #(
    .CAPACITY  (CAPACITY),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
